// ===== design/lpcp_pkg.sv =====
// Shared types and constants for the lidar point camera projection block.
package lpcp_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int PIXEL_BITS_DEF = 16;
	localparam int NUM_COEFF      = 12;
	localparam int QDEPTH         = 4;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_LOAD  = 1'b1;

	typedef enum logic [2:0] {
		CFG_ROI_X     = 3'd0,
		CFG_ROI_Y     = 3'd1,
		CFG_ROI_Z     = 3'd2,
		CFG_FINISH_X  = 3'd3,
		CFG_FINISH_Y  = 3'd4,
		CFG_FINISH_Z  = 3'd5,
		CFG_IMAGE_SIZE = 3'd6,
		CFG_FINISH_MODE = 3'd7
	} cfg_idx_t;

	localparam logic [31:0] IMAGE_SIZE_RST = 32'd70780800;

	typedef struct packed {
		logic              kind;
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
		logic signed [31:0] z_coord;
		logic [3:0]        coeff_index;
		logic signed [31:0] coeff_value;
	} in_item_t;

	typedef struct packed {
		logic              kept;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [15:0]       pixel_col;
		logic [15:0]       pixel_row;
	} out_item_t;

	// classified point handed from front to back
	typedef struct packed {
		logic               box_ok;
		logic [2:0][31:0]   pt;
		logic [2:0][2:0][63:0] prod;   // [row][col] coefficient * coordinate
		logic [2:0][31:0]   offs;      // fourth column per row
	} q_entry_t;

endpackage

// ===== design/lpcp_if.sv =====
// Valid/ready channel interfaces for point items and result items.
interface lpcp_in_if;
	import lpcp_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lpcp_out_if;
	import lpcp_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/lpcp_front.sv =====
// Front: accepts items, loads coefficients, checks the box and forms the nine products.
module lpcp_front import lpcp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	lpcp_in_if.sink          in_ch,
	input  logic [2:0][63:0] box,
	output logic             push_valid,
	output q_entry_t         push_data,
	input  logic             push_ready
);

	localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

	logic [31:0] coeff_q [NUM_COEFF];
	logic        valid_s1;
	q_entry_t    entry_s1;
	logic        acc;
	q_entry_t    nxt;
	logic [2:0]  in_box;

	assign in_ch.ready = !valid_s1 || push_ready;
	assign acc = in_ch.valid && in_ch.ready;
	assign push_valid = valid_s1;
	assign push_data = entry_s1;

	always_comb begin
		nxt.pt[0] = in_ch.data.x_coord;
		nxt.pt[1] = in_ch.data.y_coord;
		nxt.pt[2] = in_ch.data.z_coord;
		for (int a = 0; a < 3; a++) begin
			in_box[a] = ($signed(box[a][31:0]) < $signed(nxt.pt[a]))
				&& ($signed(nxt.pt[a]) < $signed(box[a][63:32]));
		end
		nxt.box_ok = &in_box;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				nxt.prod[r][c] = 64'($signed(coeff_q[r*4+c]) * $signed(nxt.pt[c]));
			end
			nxt.offs[r] = coeff_q[r*4+3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int i = 0; i < NUM_COEFF; i++) begin
				coeff_q[i] <= (i == 0 || i == 5 || i == 10) ? ONE : 32'd0;
			end
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= acc && (in_ch.data.kind == KIND_POINT);
			end
			if (acc && in_ch.data.kind == KIND_LOAD
				&& in_ch.data.coeff_index < 4'(NUM_COEFF)) begin
				coeff_q[in_ch.data.coeff_index] <= in_ch.data.coeff_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && in_ch.data.kind == KIND_POINT) begin
			entry_s1 <= nxt;
		end
	end

endmodule

// ===== design/lpcp_queue.sv =====
// Short queue of classified points between front and back.
module lpcp_queue import lpcp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	input  q_entry_t push_data,
	output logic     push_ready,
	output logic     head_valid,
	output q_entry_t head_data,
	input  logic     pop
);

	localparam int PW = $clog2(QDEPTH);

	q_entry_t        mem_q [QDEPTH];
	logic [PW-1:0]   wptr_q, rptr_q;
	logic [PW:0]     count_q;
	logic            do_push, do_pop;

	assign push_ready = count_q != (PW+1)'(QDEPTH);
	assign head_valid = count_q != '0;
	assign head_data = mem_q[rptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop) rptr_q <= rptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= push_data;
	end

endmodule

// ===== design/lpcp_back.sv =====
// Back: truncates and sums the products, divides by depth bit by bit, checks the image.
module lpcp_back import lpcp_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  q_entry_t    head_data,
	output logic        pop,
	input  logic [31:0] image_size,
	lpcp_out_if.source  out_ch
);

	localparam int DW = 64 + PIXEL_BITS;
	localparam logic [63:0] BIAS = (64'd1 << FRAC_BITS) - 64'd1;

	typedef struct packed {
		logic              box_ok;
		logic [2:0][31:0]  pt;
		logic              wpos;
		logic [DW-1:0]     wd;
		logic              neg_u, neg_v, ovf_u, ovf_v;
		logic [DW-1:0]     ru, rv;
		logic [PIXEL_BITS-1:0] qu, qv;
	} div_t;

	logic en;
	logic valid_s1, valid_s2;
	logic box_s1, box_s2;
	logic [2:0][31:0] pt_s1, pt_s2;
	logic [2:0][2:0][63:0] tr_s1;
	logic [2:0][31:0] offs_s1;
	logic [2:0][63:0] sum_s2;
	logic [2:0][2:0][63:0] tr_n;
	logic [2:0][63:0] sum_n;
	div_t div_s [PIXEL_BITS+1];
	logic div_vld_s [PIXEL_BITS+1];
	div_t d0_n;
	logic [63:0] au, av;
	out_item_t res_q;
	logic res_valid_q;
	logic [PIXEL_BITS-1:0] width, height;
	logic ok_col, ok_row, kept;
	div_t fin;

	assign en = !res_valid_q || out_ch.ready;
	assign pop = en && head_valid;

	// truncate toward zero: add bias to negative products before the shift
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				tr_n[r][c] = 64'(($signed(head_data.prod[r][c])
					+ $signed(head_data.prod[r][c][63] ? BIAS : 64'd0)) >>> FRAC_BITS);
			end
		end
		for (int r = 0; r < 3; r++) begin
			sum_n[r] = 64'($signed(tr_s1[r][0]) + $signed(tr_s1[r][1])
				+ $signed(tr_s1[r][2]) + $signed(offs_s1[r]));
		end
	end

	always_comb begin
		au = sum_s2[0][63] ? 64'(-$signed(sum_s2[0])) : sum_s2[0];
		av = sum_s2[1][63] ? 64'(-$signed(sum_s2[1])) : sum_s2[1];
		d0_n.box_ok = box_s2;
		d0_n.pt = pt_s2;
		d0_n.wpos = !sum_s2[2][63] && (sum_s2[2] != 64'd0);
		d0_n.wd = DW'(sum_s2[2]);
		d0_n.neg_u = sum_s2[0][63];
		d0_n.neg_v = sum_s2[1][63];
		d0_n.ovf_u = DW'(au) >= (d0_n.wd << PIXEL_BITS);
		d0_n.ovf_v = DW'(av) >= (d0_n.wd << PIXEL_BITS);
		d0_n.ru = DW'(au);
		d0_n.rv = DW'(av);
		d0_n.qu = '0;
		d0_n.qv = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			div_vld_s[0] <= 1'b0;
		end else if (en) begin
			valid_s1 <= head_valid;
			valid_s2 <= valid_s1;
			div_vld_s[0] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tr_s1 <= tr_n;
			offs_s1 <= head_data.offs;
			box_s1 <= head_data.box_ok;
			pt_s1 <= head_data.pt;
			sum_s2 <= sum_n;
			box_s2 <= box_s1;
			pt_s2 <= pt_s1;
			div_s[0] <= d0_n;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar i = 0; i < PIXEL_BITS; i++) begin : g_div
		localparam int K = PIXEL_BITS - 1 - i;
		div_t nx;
		logic [DW-1:0] sh;
		always_comb begin
			nx = div_s[i];
			sh = div_s[i].wd << K;
			if (div_s[i].ru >= sh) begin
				nx.ru = div_s[i].ru - sh;
				nx.qu[K] = 1'b1;
			end
			if (div_s[i].rv >= sh) begin
				nx.rv = div_s[i].rv - sh;
				nx.qv[K] = 1'b1;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[i+1] <= 1'b0;
			end else if (en) begin
				div_vld_s[i+1] <= div_vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) div_s[i+1] <= nx;
		end
	end

	always_comb begin
		fin = div_s[PIXEL_BITS];
		width = image_size[PIXEL_BITS-1:0];
		height = image_size[16 +: PIXEL_BITS];
		// a negative numerator is fine only when its quotient truncates to zero
		ok_col = !fin.ovf_u && (fin.neg_u ? (fin.qu == '0) : (fin.qu < width));
		ok_row = !fin.ovf_v && (fin.neg_v ? (fin.qv == '0) : (fin.qv < height));
		kept = fin.box_ok && fin.wpos && ok_col && ok_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= div_vld_s[PIXEL_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.kept <= kept;
			res_q.out_x <= kept ? fin.pt[0] : 32'd0;
			res_q.out_y <= kept ? fin.pt[1] : 32'd0;
			res_q.out_z <= kept ? fin.pt[2] : 32'd0;
			res_q.pixel_col <= kept ? 16'(fin.qu) : 16'd0;
			res_q.pixel_row <= kept ? 16'(fin.qv) : 16'd0;
		end
	end

	assign out_ch.valid = res_valid_q;
	assign out_ch.data = res_q;

endmodule

// ===== design/lidar_point_camera_projection.sv =====
// Top level of the lidar point camera projection block.
// One item per clock in steady state while out_ch is ready. A point item gives
// one result: one front stage forms the nine coefficient products, a
// four-entry queue decouples it from the back, where two stages truncate and
// sum, one takes magnitudes, and one stage per pixel bit divides column and
// row by depth. A coefficient-load item updates the matrix at acceptance, so
// later points see it, and gives no result. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
module lidar_point_camera_projection import lpcp_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lpcp_in_if.sink     in_ch,
	lpcp_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [2:0][63:0] roi_q, fin_q, box;
	logic [31:0]      image_size_q;
	logic             finish_mode_q;
	logic             push_valid, push_ready, head_valid, pop;
	q_entry_t         push_data, head_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_q <= '0;
			fin_q <= '0;
			image_size_q <= IMAGE_SIZE_RST;
			finish_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ROI_X:       roi_q[0] <= cfg_data;
				CFG_ROI_Y:       roi_q[1] <= cfg_data;
				CFG_ROI_Z:       roi_q[2] <= cfg_data;
				CFG_FINISH_X:    fin_q[0] <= cfg_data;
				CFG_FINISH_Y:    fin_q[1] <= cfg_data;
				CFG_FINISH_Z:    fin_q[2] <= cfg_data;
				CFG_IMAGE_SIZE:  image_size_q <= cfg_data[31:0];
				CFG_FINISH_MODE: finish_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign box = finish_mode_q ? fin_q : roi_q;

	lpcp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .in_ch, .box,
		.push_valid, .push_data, .push_ready
	);

	lpcp_queue u_queue (
		.clk, .arst_n, .push_valid, .push_data, .push_ready,
		.head_valid, .head_data, .pop
	);

	lpcp_back #(.FRAC_BITS(FRAC_BITS), .PIXEL_BITS(PIXEL_BITS)) u_back (
		.clk, .arst_n, .head_valid, .head_data, .pop,
		.image_size(image_size_q), .out_ch
	);

	a_kept_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.kept |->
			(out_ch.data.pixel_col < 16'(image_size_q[PIXEL_BITS-1:0]))
			&& (out_ch.data.pixel_row < 16'(image_size_q[16 +: PIXEL_BITS])))
		else $error("kept pixel outside image");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.data.kept |->
			out_ch.data.out_x == 32'd0 && out_ch.data.out_y == 32'd0
			&& out_ch.data.out_z == 32'd0 && out_ch.data.pixel_col == 16'd0
			&& out_ch.data.pixel_row == 16'd0)
		else $error("rejected item carries nonzero fields");

	a_queue_flow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

endmodule
